@@ rtl/arp_neighbor_table_with_aging_core_assert.svh @@
// Assertion macros for the neighbor table core.
`ifndef ARP_NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define ARP_NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ARPNT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define ARPNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ARPNT_ASSERT_SAME(label, clk, rst, ante, cons)
`define ARPNT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/arpnt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arpnt_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIVE_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic [LIVE_W-1:0] LIVE_TIME_RESET = 16'd50;

  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_AGE     = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_REFRESHED = 2'd0,
    STAT_INSERTED  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_AGED      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/arpnt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arpnt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output arpnt_pkg::cmd_t  cmd,
  input  arpnt_pkg::sts_t  sts
);
  import arpnt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The result register may only be reloaded once the last item is gone.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arpnt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arpnt_datapath #(
  parameter int unsigned DEPTH = arpnt_pkg::DEFAULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  arpnt_pkg::cmd_t                cmd,
  output arpnt_pkg::sts_t                sts,
  input  logic                           cfg_we,
  input  logic [arpnt_pkg::LIVE_W-1:0]   cfg_data,
  input  logic                           action,
  input  logic [arpnt_pkg::MAC_W-1:0]    sender_mac,
  input  logic [arpnt_pkg::IP_W-1:0]     sender_ip,
  input  logic [arpnt_pkg::TIME_W-1:0]   time_now,
  output logic [arpnt_pkg::STAT_W-1:0]   status,
  output logic [arpnt_pkg::SLOT_W-1:0]   slot,
  output logic [arpnt_pkg::COUNT_W-1:0]  removed_count,
  output logic [arpnt_pkg::COUNT_W-1:0]  entry_count
);
  import arpnt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);
  localparam logic [AW:0] LAST_C  = (AW + 1)'(DEPTH - 1);

  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] stamp;
  } row_t;

  row_t mem [DEPTH];
  row_t rdata;
  logic we;
  logic [AW-1:0] wa;
  row_t wd;

  logic [LIVE_W-1:0] live_time;
  logic              op_action;
  logic [MAC_W-1:0]  op_mac;
  logic [IP_W-1:0]   op_ip;
  logic [TIME_W-1:0] op_now;

  logic [AW:0]   cnt;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [CW-1:0] removed;
  logic [CW-1:0] valid_total;
  logic [CW-1:0] valid_total_next;

  logic [TIME_W:0] deadline;
  logic            expire;
  logic            match;
  logic            free_first;
  logic            insert;
  status_t         status_next;
  logic [AW-1:0]   slot_next;

  // Memory: one write port, one registered read port walking with cnt.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[cnt[AW-1:0]];
  end

  always_comb begin
    deadline   = {1'b0, rdata.stamp} + (TIME_W + 1)'(live_time);
    expire     = rd_pend && (op_action == ACT_AGE) && rdata.valid &&
                 (deadline < {1'b0, op_now});
    match      = rd_pend && (op_action == ACT_OBSERVE) && rdata.valid && !hit_found &&
                 (rdata.mac == op_mac) && (rdata.ip == op_ip);
    free_first = rd_pend && (op_action == ACT_OBSERVE) && !rdata.valid && !free_found;
    insert     = cmd.commit && (op_action == ACT_OBSERVE) && !hit_found && free_found;

    we = 1'b0;
    wa = rd_idx;
    wd = rdata;
    if (cmd.clear) begin
      we = 1'b1;
      wa = cnt[AW-1:0];
      wd = '0;
    end else if (expire) begin
      we       = 1'b1;
      wd.valid = 1'b0;
    end else if (cmd.commit && (op_action == ACT_OBSERVE) && (hit_found || free_found)) begin
      // A refresh or insert writes the row with the addresses and new stamp.
      we = 1'b1;
      wa = hit_found ? hit_idx : free_idx;
      wd = {1'b1, op_mac, op_ip, op_now};
    end

    if (expire) begin
      valid_total_next = valid_total - 1'b1;
    end else if (insert) begin
      valid_total_next = valid_total + 1'b1;
    end else begin
      valid_total_next = valid_total;
    end

    if (op_action == ACT_AGE) begin
      status_next = STAT_AGED;
      slot_next   = '0;
    end else if (hit_found) begin
      status_next = STAT_REFRESHED;
      slot_next   = hit_idx;
    end else if (free_found) begin
      status_next = STAT_INSERTED;
      slot_next   = free_idx;
    end else begin
      status_next = STAT_FULL;
      slot_next   = '0;
    end

    sts.cnt_last  = (cnt == LAST_C);
    sts.scan_done = (cnt == DEPTH_C) && !rd_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_time   <= LIVE_TIME_RESET;
      cnt         <= '0;
      rd_pend     <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
      valid_total <= '0;
    end else begin
      if (cfg_we) begin
        live_time <= cfg_data;
      end
      if (cmd.start) begin
        cnt        <= '0;
        rd_pend    <= 1'b0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.clear || (cmd.scan && (cnt != DEPTH_C))) begin
          cnt <= cnt + 1'b1;
        end
        rd_pend <= cmd.scan && (cnt != DEPTH_C);
        if (match) begin
          hit_found <= 1'b1;
        end
        if (free_first) begin
          free_found <= 1'b1;
        end
      end
      valid_total <= valid_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_action <= action;
      op_mac    <= sender_mac;
      op_ip     <= sender_ip;
      op_now    <= time_now;
      removed   <= '0;
    end else if (expire) begin
      removed <= removed + 1'b1;
    end
    rd_idx <= cnt[AW-1:0];
    if (match) begin
      hit_idx <= rd_idx;
    end
    if (free_first) begin
      free_idx <= rd_idx;
    end
    if (cmd.commit) begin
      status        <= status_next;
      slot          <= SLOT_W'(slot_next);
      removed_count <= COUNT_W'(removed);
      entry_count   <= COUNT_W'(valid_total_next);
    end
  end

endmodule

`default_nettype wire

@@ rtl/arp_neighbor_table_with_aging_core.sv @@
// Neighbor table with aging.
// Input channel (in_valid / in_ready) carries one item: action selects observe
// (sender_mac, sender_ip, time_now) or age (time_now is the current time).
// Output channel (out_valid / out_ready) returns one result item per input item:
// status, slot, removed_count and entry_count.
// cfg_we / cfg_data write live_time (16 bits, reset 50).
// Each item walks the whole table through the single read port of the table
// memory, one entry per cycle, and its result is then registered in the commit
// step, raising out_valid; a new item is taken only after that commit.
// in_ready is high only between items; the result sits in an output register,
// so the next item may be accepted while a result still waits for out_ready.
// A stalled receiver holds the next result in the commit step until the
// current one is taken.
// After reset the table memory is cleared, one entry per cycle; in_ready stays
// low during that pass, cfg writes are taken.
`timescale 1ns / 1ps
`default_nettype none

`include "arp_neighbor_table_with_aging_core_assert.svh"

module arp_neighbor_table_with_aging_core #(
  parameter int unsigned TABLE_DEPTH = arpnt_pkg::DEFAULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [arpnt_pkg::MAC_W-1:0]    sender_mac,
  input  logic [arpnt_pkg::IP_W-1:0]     sender_ip,
  input  logic [arpnt_pkg::TIME_W-1:0]   time_now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [arpnt_pkg::STAT_W-1:0]   status,
  output logic [arpnt_pkg::SLOT_W-1:0]   slot,
  output logic [arpnt_pkg::COUNT_W-1:0]  removed_count,
  output logic [arpnt_pkg::COUNT_W-1:0]  entry_count,
  input  logic                           cfg_we,
  input  logic [arpnt_pkg::LIVE_W-1:0]   cfg_data
);
  import arpnt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  arpnt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  arpnt_datapath #(
    .DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .action        (action),
    .sender_mac    (sender_mac),
    .sender_ip     (sender_ip),
    .time_now      (time_now),
    .status        (status),
    .slot          (slot),
    .removed_count (removed_count),
    .entry_count   (entry_count)
  );

  // Once an item is taken, the table walk must finish before the next one.
  `ARPNT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ARPNT_ASSERT_SAME(a_slot_zero, clk, rst,
    out_valid && (status == STAT_FULL || status == STAT_AGED), slot == '0)
  `ARPNT_ASSERT_SAME(a_removed_only_aging, clk, rst,
    out_valid && status != STAT_AGED, removed_count == '0)

endmodule

`default_nettype wire
